// File: hdl/udrb_pkg.sv
// ============================================================================
// udrb_pkg
// Shared types, codes and default sizes for the dual UART ring buffer.
// ============================================================================
package udrb_pkg;

    localparam int RX_DEPTH_DEF = 64;
    localparam int TX_DEPTH_DEF = 64;
    localparam int FILL_W       = 7;

    localparam logic [1:0] OP_LINE_RX  = 2'd0;
    localparam logic [1:0] OP_TX_EMPTY = 2'd1;
    localparam logic [1:0] OP_CPU_PUT  = 2'd2;
    localparam logic [1:0] OP_CPU_GET  = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_EMPTY   = 2'd2;
    localparam logic [1:0] STAT_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_in;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        data_out;
        logic              send_valid;
        logic [7:0]        send_byte;
        logic              tx_irq_enabled;
        logic [FILL_W-1:0] rx_fill;
        logic [FILL_W-1:0] tx_fill;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic issue;
        logic respond;
    } ctrl_cmd_t;

    typedef struct packed {
        logic inc_wr;
        logic inc_rd;
    } ring_cmd_t;

    typedef struct packed {
        logic can_write;
        logic not_empty;
    } ring_stat_t;

endpackage

// File: hdl/udrb_ram.sv
// ============================================================================
// udrb_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module udrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/udrb_ring_ptr.sv
// ============================================================================
// udrb_ring_ptr
// Write and read pointers of one ring, counting modulo twice the depth,
// with slot addresses, fill level and full/empty status.
// ============================================================================
module udrb_ring_ptr #(
    parameter int DEPTH = udrb_pkg::RX_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  udrb_pkg::ring_cmd_t         cmd,
    output logic [$clog2(DEPTH)-1:0]    wr_slot,
    output logic [$clog2(DEPTH)-1:0]    rd_slot,
    output udrb_pkg::ring_stat_t        stat,
    output logic [udrb_pkg::FILL_W-1:0] fill
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(2 * DEPTH);

    localparam logic [PW-1:0] PTR_MAX = PW'(2 * DEPTH - 1);
    localparam logic [PW-1:0] SLOT_D  = PW'(DEPTH);
    localparam logic [PW-1:0] LIMIT   = PW'(DEPTH - 2);
    localparam logic [PW:0]   TWO_D   = (PW + 1)'(2 * DEPTH);

    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW-1:0] wr_fold, rd_fold;
    logic [PW-1:0] level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    // advance with wrap at twice the depth
    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (cmd.inc_wr)
        begin
            wr_next = (wr_reg == PTR_MAX) ? '0 : wr_reg + 1'b1;
        end
        if (cmd.inc_rd)
        begin
            rd_next = (rd_reg == PTR_MAX) ? '0 : rd_reg + 1'b1;
        end
    end

    assign wr_fold = (wr_reg >= SLOT_D) ? wr_reg - SLOT_D : wr_reg;
    assign rd_fold = (rd_reg >= SLOT_D) ? rd_reg - SLOT_D : rd_reg;
    assign wr_slot = AW'(wr_fold);
    assign rd_slot = AW'(rd_fold);

    always_comb
    begin
        if (wr_reg >= rd_reg)
        begin
            level = wr_reg - rd_reg;
        end
        else
        begin
            level = PW'({1'b0, wr_reg} + TWO_D - {1'b0, rd_reg});
        end
    end

    assign stat.can_write = (level < LIMIT);
    assign stat.not_empty = (level != '0);
    assign fill           = udrb_pkg::FILL_W'(level);

endmodule

// File: hdl/udrb_datapath.sv
// ============================================================================
// udrb_datapath
// Ring memories, pointers and interrupt enable flag; decides each request
// and holds the response fields until they are strobed out.
// ============================================================================
module udrb_datapath #(
    parameter int RX_DEPTH = udrb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = udrb_pkg::TX_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  udrb_pkg::ctrl_cmd_t cmd,
    input  udrb_pkg::req_t      request,
    output udrb_pkg::rsp_t      result
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);

    udrb_pkg::ring_cmd_t  rx_cmd, tx_cmd;
    udrb_pkg::ring_stat_t rx_stat, tx_stat;
    logic [RX_AW-1:0]     rx_wr_slot, rx_rd_slot;
    logic [TX_AW-1:0]     tx_wr_slot, tx_rd_slot;
    logic [udrb_pkg::FILL_W-1:0] rx_fill, tx_fill;
    logic [7:0]           rx_rdata, tx_rdata;

    logic       flag_reg, flag_next;
    logic [1:0] status_reg, status_next;
    logic       send_reg, send_next;
    logic       get_reg, get_next;

    udrb_ring_ptr #(.DEPTH(RX_DEPTH)) u_rx_ptr (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (rx_cmd),
        .wr_slot (rx_wr_slot),
        .rd_slot (rx_rd_slot),
        .stat    (rx_stat),
        .fill    (rx_fill)
    );

    udrb_ring_ptr #(.DEPTH(TX_DEPTH)) u_tx_ptr (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (tx_cmd),
        .wr_slot (tx_wr_slot),
        .rd_slot (tx_rd_slot),
        .stat    (tx_stat),
        .fill    (tx_fill)
    );

    udrb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_cmd.inc_wr),
        .waddr (rx_wr_slot),
        .wdata (request.data_in),
        .re    (rx_cmd.inc_rd),
        .raddr (rx_rd_slot),
        .rdata (rx_rdata)
    );

    udrb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_cmd.inc_wr),
        .waddr (tx_wr_slot),
        .wdata (request.data_in),
        .re    (tx_cmd.inc_rd),
        .raddr (tx_rd_slot),
        .rdata (tx_rdata)
    );

    always_comb
    begin
        rx_cmd      = '0;
        tx_cmd      = '0;
        flag_next   = flag_reg;
        status_next = status_reg;
        send_next   = send_reg;
        get_next    = get_reg;
        if (cmd.issue)
        begin
            status_next = udrb_pkg::STAT_OK;
            send_next   = 1'b0;
            get_next    = 1'b0;
            case (request.op)
                udrb_pkg::OP_LINE_RX:
                begin
                    if (rx_stat.can_write)
                    begin
                        rx_cmd.inc_wr = 1'b1;
                    end
                    else
                    begin
                        status_next = udrb_pkg::STAT_FULL;
                    end
                end
                udrb_pkg::OP_TX_EMPTY:
                begin
                    if (!flag_reg)
                    begin
                        status_next = udrb_pkg::STAT_IGNORED;
                    end
                    else if (tx_stat.not_empty)
                    begin
                        tx_cmd.inc_rd = 1'b1;
                        send_next     = 1'b1;
                    end
                    else
                    begin
                        flag_next   = 1'b0;
                        status_next = udrb_pkg::STAT_EMPTY;
                    end
                end
                udrb_pkg::OP_CPU_PUT:
                begin
                    if (tx_stat.can_write)
                    begin
                        tx_cmd.inc_wr = 1'b1;
                        flag_next     = 1'b1;
                    end
                    else
                    begin
                        status_next = udrb_pkg::STAT_FULL;
                    end
                end
                udrb_pkg::OP_CPU_GET:
                begin
                    if (rx_stat.not_empty)
                    begin
                        rx_cmd.inc_rd = 1'b1;
                        get_next      = 1'b1;
                    end
                    else
                    begin
                        status_next = udrb_pkg::STAT_EMPTY;
                    end
                end
                default:
                begin
                    status_next = udrb_pkg::STAT_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= 1'b1;
            status_reg <= udrb_pkg::STAT_OK;
            send_reg   <= 1'b0;
            get_reg    <= 1'b0;
        end
        else
        begin
            flag_reg   <= flag_next;
            status_reg <= status_next;
            send_reg   <= send_next;
            get_reg    <= get_next;
        end
    end

    always_comb
    begin
        result                = '0;
        if (cmd.respond)
        begin
            result.status         = status_reg;
            result.data_out       = get_reg ? rx_rdata : 8'h00;
            result.send_valid     = send_reg;
            result.send_byte      = send_reg ? tx_rdata : 8'h00;
            result.tx_irq_enabled = flag_reg;
            result.rx_fill        = rx_fill;
            result.tx_fill        = tx_fill;
        end
    end

endmodule

// File: hdl/udrb_ctrl.sv
// ============================================================================
// udrb_ctrl
// Request sequencer: accept a request, then strobe its response.
// ============================================================================
module udrb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output udrb_pkg::ctrl_cmd_t cmd
);

    udrb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= udrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            udrb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = udrb_pkg::ST_RESP;
                end
            end
            udrb_pkg::ST_RESP:
            begin
                state_next = udrb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = udrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        done = 1'b0;
        case (state_reg)
            udrb_pkg::ST_IDLE:
            begin
                cmd.issue = start;
            end
            udrb_pkg::ST_RESP:
            begin
                busy        = 1'b1;
                done        = 1'b1;
                cmd.respond = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: hdl/uart_dual_ring_buffer_top.sv
// ============================================================================
// uart_dual_ring_buffer_top
// UART receive and transmit ring buffers with CPU put/get access.
// ============================================================================
// Each request is accepted on the edge where start is high and busy is low;
// the ring memory is read or written on that edge, and the response appears
// in the next cycle with done high for that single cycle. busy is high
// during the response cycle, so no new request is accepted while a response
// is shown. The receiver must take every response in the cycle done is high.
// Each ring holds at most depth minus 2 bytes; no clearing pass is needed.
module uart_dual_ring_buffer_top #(
    parameter int RX_DEPTH = udrb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = udrb_pkg::TX_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  udrb_pkg::req_t request,
    output logic           done,
    output udrb_pkg::rsp_t result
);

    udrb_pkg::ctrl_cmd_t cmd;

    udrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    udrb_datapath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

endmodule

// File: hdl/udrb_checker.sv
// ============================================================================
// udrb_checker
// Port-level checks of request/response timing and response consistency.
// ============================================================================
module udrb_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input udrb_pkg::req_t request,
    input logic           done,
    input udrb_pkg::rsp_t result
);

    a_accept_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted request not answered in next cycle");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("response strobe longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("response shown while ready for a request");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != udrb_pkg::STAT_OK)
            |-> (result.data_out == 8'h00 && !result.send_valid))
        else $error("failed request returned data");

    a_no_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.send_valid) |-> (result.send_byte == 8'h00))
        else $error("send byte set without send valid");

endmodule

bind uart_dual_ring_buffer_top udrb_checker u_udrb_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Checks the dual UART ring buffer: a short table of directed requests, then
// about 1500 random requests grouped in phases that fill and drain each ring,
// all compared field by field with hand-written or predicted responses.
// ============================================================================
module tb_top;

    localparam int RXD         = udrb_pkg::RX_DEPTH_DEF;
    localparam int TXD         = udrb_pkg::TX_DEPTH_DEF;
    localparam int RAND_ITEMS  = 1500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_MAX   = 50;

    typedef struct {
        logic [1:0]      op;
        logic [7:0]      data;
        bit              typed;
        udrb_pkg::rsp_t  want;
    } dir_row_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    udrb_pkg::req_t request;
    logic           done;
    udrb_pkg::rsp_t result;

    bit             has_want;
    udrb_pkg::rsp_t hand_rsp;

    logic [7:0] rx_store [RXD];
    logic [7:0] tx_store [TXD];
    int   rx_wr  = 0;
    int   rx_rd  = 0;
    int   tx_wr  = 0;
    int   tx_rd  = 0;
    bit   tx_irq = 1'b1;

    udrb_pkg::rsp_t expected_rsp [$];
    dir_row_t       dir_rows [$];
    int             mismatches   = 0;
    int             sent_items   = 0;
    int             cycle_count  = 0;
    int             burst_left   = 0;

    uart_dual_ring_buffer_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int ring_count(int wr, int rd, int depth);
        return (wr - rd + 2 * depth) % (2 * depth);
    endfunction

    function automatic udrb_pkg::rsp_t predict_ring_step(udrb_pkg::req_t r);
        udrb_pkg::rsp_t p;
        int   rxf;
        int   txf;
        p   = '0;
        rxf = ring_count(rx_wr, rx_rd, RXD);
        txf = ring_count(tx_wr, tx_rd, TXD);
        case (r.op)
            udrb_pkg::OP_LINE_RX:
                if (rxf < RXD - 2)
                begin
                    rx_store[rx_wr % RXD] = r.data_in;
                    rx_wr = (rx_wr + 1) % (2 * RXD);
                end
                else
                    p.status = udrb_pkg::STAT_FULL;
            udrb_pkg::OP_TX_EMPTY:
                if (!tx_irq)
                    p.status = udrb_pkg::STAT_IGNORED;
                else if (txf != 0)
                begin
                    p.send_valid = 1'b1;
                    p.send_byte  = tx_store[tx_rd % TXD];
                    tx_rd = (tx_rd + 1) % (2 * TXD);
                end
                else
                begin
                    tx_irq   = 1'b0;
                    p.status = udrb_pkg::STAT_EMPTY;
                end
            udrb_pkg::OP_CPU_PUT:
                if (txf < TXD - 2)
                begin
                    tx_store[tx_wr % TXD] = r.data_in;
                    tx_wr  = (tx_wr + 1) % (2 * TXD);
                    tx_irq = 1'b1;
                end
                else
                    p.status = udrb_pkg::STAT_FULL;
            default:
                if (rxf != 0)
                begin
                    p.data_out = rx_store[rx_rd % RXD];
                    rx_rd = (rx_rd + 1) % (2 * RXD);
                end
                else
                    p.status = udrb_pkg::STAT_EMPTY;
        endcase
        p.tx_irq_enabled = tx_irq;
        p.rx_fill        = udrb_pkg::FILL_W'(ring_count(rx_wr, rx_rd, RXD));
        p.tx_fill        = udrb_pkg::FILL_W'(ring_count(tx_wr, tx_rd, TXD));
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_MAX)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        udrb_pkg::rsp_t pred;
        udrb_pkg::rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("result with no request pending");
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("status", result.status, want.status);
                    check_field("data_out", result.data_out, want.data_out);
                    check_field("send_valid", result.send_valid, want.send_valid);
                    check_field("send_byte", result.send_byte, want.send_byte);
                    check_field("tx_irq_enabled", result.tx_irq_enabled,
                                want.tx_irq_enabled);
                    check_field("rx_fill", result.rx_fill, want.rx_fill);
                    check_field("tx_fill", result.tx_fill, want.tx_fill);
                end
            end
            if (start && !busy)
            begin
                pred = predict_ring_step(request);
                sent_items++;
                expected_rsp.push_back(has_want ? hand_rsp : pred);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL uart_dual_ring_buffer_top");
            $finish;
        end
    end

    function automatic udrb_pkg::rsp_t make_rsp(logic [1:0] st, logic [7:0] dout, logic sv,
                                                logic [7:0] sb, logic irq, int rxf, int txf);
        udrb_pkg::rsp_t r;
        r.status         = st;
        r.data_out       = dout;
        r.send_valid     = sv;
        r.send_byte      = sb;
        r.tx_irq_enabled = irq;
        r.rx_fill        = udrb_pkg::FILL_W'(rxf);
        r.tx_fill        = udrb_pkg::FILL_W'(txf);
        return r;
    endfunction

    function automatic void add_row(logic [1:0] op, logic [7:0] d);
        dir_rows.push_back('{op, d, 1'b0, udrb_pkg::rsp_t'('0)});
    endfunction

    function automatic void add_typed(logic [1:0] op, logic [7:0] d, udrb_pkg::rsp_t want);
        dir_rows.push_back('{op, d, 1'b1, want});
    endfunction

    task automatic issue_request(logic [1:0] op, logic [7:0] d, bit typed,
                                 udrb_pkg::rsp_t want);
        int             gap;
        udrb_pkg::req_t r;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.op      = op;
        r.data_in = d;
        start    <= 1'b1;
        request  <= r;
        has_want <= typed;
        hand_rsp <= want;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [1:0] pick_op(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == 4 || roll >= 85)
            return 2'($urandom_range(0, 3));
        case (mode)
            0:       return udrb_pkg::OP_LINE_RX;
            1:       return udrb_pkg::OP_CPU_GET;
            2:       return udrb_pkg::OP_CPU_PUT;
            default: return udrb_pkg::OP_TX_EMPTY;
        endcase
    endfunction

    initial
    begin
        int mode;
        int phase_len;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        request  <= '0;
        has_want <= 1'b0;
        hand_rsp <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_typed(udrb_pkg::OP_CPU_GET,  8'h00,
                  make_rsp(udrb_pkg::STAT_EMPTY,   8'h00, 0, 8'h00, 1, 0, 0));
        add_typed(udrb_pkg::OP_TX_EMPTY, 8'h00,
                  make_rsp(udrb_pkg::STAT_EMPTY,   8'h00, 0, 8'h00, 0, 0, 0));
        add_typed(udrb_pkg::OP_TX_EMPTY, 8'hFF,
                  make_rsp(udrb_pkg::STAT_IGNORED, 8'h00, 0, 8'h00, 0, 0, 0));
        add_typed(udrb_pkg::OP_CPU_GET,  8'hFF,
                  make_rsp(udrb_pkg::STAT_EMPTY,   8'h00, 0, 8'h00, 0, 0, 0));
        add_typed(udrb_pkg::OP_CPU_PUT,  8'h00,
                  make_rsp(udrb_pkg::STAT_OK,      8'h00, 0, 8'h00, 1, 0, 1));
        add_typed(udrb_pkg::OP_CPU_PUT,  8'hFF,
                  make_rsp(udrb_pkg::STAT_OK,      8'h00, 0, 8'h00, 1, 0, 2));
        add_row(udrb_pkg::OP_CPU_PUT, 8'h5A);
        add_typed(udrb_pkg::OP_TX_EMPTY, 8'h00,
                  make_rsp(udrb_pkg::STAT_OK,      8'h00, 1, 8'h00, 1, 0, 2));
        add_typed(udrb_pkg::OP_TX_EMPTY, 8'h00,
                  make_rsp(udrb_pkg::STAT_OK,      8'h00, 1, 8'hFF, 1, 0, 1));
        add_row(udrb_pkg::OP_TX_EMPTY, 8'h33);
        add_typed(udrb_pkg::OP_TX_EMPTY, 8'h00,
                  make_rsp(udrb_pkg::STAT_EMPTY,   8'h00, 0, 8'h00, 0, 0, 0));
        add_typed(udrb_pkg::OP_LINE_RX,  8'h00,
                  make_rsp(udrb_pkg::STAT_OK,      8'h00, 0, 8'h00, 0, 1, 0));
        add_typed(udrb_pkg::OP_LINE_RX,  8'hFF,
                  make_rsp(udrb_pkg::STAT_OK,      8'h00, 0, 8'h00, 0, 2, 0));
        add_row(udrb_pkg::OP_LINE_RX, 8'hA5);
        add_typed(udrb_pkg::OP_CPU_GET,  8'h00,
                  make_rsp(udrb_pkg::STAT_OK,      8'h00, 0, 8'h00, 0, 2, 0));
        add_typed(udrb_pkg::OP_CPU_GET,  8'h00,
                  make_rsp(udrb_pkg::STAT_OK,      8'hFF, 0, 8'h00, 0, 1, 0));
        add_row(udrb_pkg::OP_CPU_GET, 8'h00);
        add_typed(udrb_pkg::OP_CPU_GET,  8'h00,
                  make_rsp(udrb_pkg::STAT_EMPTY,   8'h00, 0, 8'h00, 0, 0, 0));
        add_row(udrb_pkg::OP_CPU_PUT, 8'h81);
        add_row(udrb_pkg::OP_LINE_RX, 8'h7E);
        add_row(udrb_pkg::OP_TX_EMPTY, 8'h00);
        add_row(udrb_pkg::OP_CPU_GET, 8'h00);

        foreach (dir_rows[i])
            issue_request(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed,
                          dir_rows[i].want);
        drain_pending();

        // most phases bias toward filling or draining one ring to reach its limits
        while (sent_items < RAND_ITEMS + dir_rows.size())
        begin
            mode      = $urandom_range(0, 4);
            phase_len = $urandom_range(10, 90);
            repeat (phase_len)
                issue_request(pick_op(mode), 8'($urandom_range(0, 255)), 1'b0, '0);
            if ($urandom_range(0, 4) == 0)
                drain_pending();
        end

        drain_pending();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS uart_dual_ring_buffer_top");
        else
            $display("FAIL uart_dual_ring_buffer_top");
        $finish;
    end

endmodule

// File: uart_dual_ring_buffer_top.f
hdl/udrb_pkg.sv
hdl/udrb_ram.sv
hdl/udrb_ring_ptr.sv
hdl/udrb_datapath.sv
hdl/udrb_ctrl.sv
hdl/uart_dual_ring_buffer_top.sv
hdl/udrb_checker.sv
dv/tb_top.sv
